// ===== design/tcce_pkg.sv =====
// shared constants for the text console cursor engine
// character codes, action codes, cell format and default geometry
// no dependencies
`default_nettype none

package tcce_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 4;

    // cell format
    localparam int CELL_W = 16;
    localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0020;
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    // character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7F;

    // action codes
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // port widths fixed by the interface
    localparam int POS_W   = 11;
    localparam int INDEX_W = 11;

endpackage

`default_nettype wire

// ===== design/tcce_addr_unit.sv =====
// shared address adder and limit compare used by the sequencer steps
// imports tcce_pkg for nothing but house consistency of widths
`default_nettype none

module tcce_addr_unit
    import tcce_pkg::*;
#(
    parameter int SW = POS_W
) (
    input  wire logic [SW-1:0] opa,
    input  wire logic [SW-1:0] opb,
    input  wire logic [SW-1:0] lim,
    output logic      [SW-1:0] sum,
    output logic               below
);

    // one add and one compare against the sweep limit
    always_comb
    begin
        sum   = opa + opb;
        below = (sum < lim);
    end

endmodule

`default_nettype wire

// ===== design/tcce_screen_ram.sv =====
// screen cell store, one write port and one registered read port
// depends on tcce_pkg for the cell width
`default_nettype none

module tcce_screen_ram
    import tcce_pkg::*;
#(
    parameter int DEPTH = COLUMNS_DEF * ROWS_DEF,
    parameter int AW    = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [CELL_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/text_console_cursor_engine_top.sv =====
// text console cursor engine: sequencer, cursor registers and config register
// depends on tcce_pkg, tcce_addr_unit and tcce_screen_ram
//
// a put item passes the exec, wrap and finish states, a read or unused action
// exec and finish; a new item is taken in the cycle the strobe shows
// a put that scrolls adds a pass moving rows up and blanking the last row, and
// a clear adds a pass over every cell, both one memory port access per cycle
// after reset a clearing pass over every cell runs with busy high
// results are a one-cycle strobe; the receiver cannot stall
`default_nettype none

module text_console_cursor_engine_top
    import tcce_pkg::*;
#(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic [7:0]         char_byte,
    input  wire logic [INDEX_W-1:0] cell_index,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data,
    output logic                    done,
    output logic [POS_W-1:0]        cursor_position,
    output logic [CELL_W-1:0]       cell_value
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = (AW + 1 > POS_W) ? AW + 1 : POS_W;
    localparam int CW    = $clog2(COLUMNS + TAB_STOP + 1);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int PW    = $clog2(TAB_STOP);

    // sequencer state codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_WRAP   = 3'd2;
    localparam logic [2:0] S_SCR_RD = 3'd3;
    localparam logic [2:0] S_SCR_WR = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [SW-1:0]     base_reg, base_next;
    logic [PW-1:0]     phase_reg, phase_next;
    logic [SW-1:0]     ptr_reg, ptr_next;
    logic [CELL_W-1:0] fill_reg, fill_next;
    logic              boot_reg, boot_next;
    logic [7:0]        attr_reg;
    logic              done_reg, done_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CELL_W-1:0] value_reg, value_next;
    logic              rd_ok_reg, rd_ok_next;

    // latched item fields
    logic [1:0]         act_reg;
    logic [7:0]         byte_reg;
    logic [INDEX_W-1:0] idx_reg;

    // shared unit operands
    logic [SW-1:0] opa, opb, lim, sum;
    logic          below;

    // memory port signals
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [CELL_W-1:0] wdata, rdata;

    logic          accept;
    logic          wrap;
    logic [RW-1:0] row_after;
    logic [SW-1:0] idx_ext;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign idx_ext   = SW'(idx_reg);

    assign done            = done_reg;
    assign cursor_position = pos_reg;
    assign cell_value      = value_reg;

    tcce_addr_unit #(.SW(SW)) u_addr (
        .opa   (opa),
        .opb   (opb),
        .lim   (lim),
        .sum   (sum),
        .below (below)
    );

    tcce_screen_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // sequencer and cursor update
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        base_next  = base_reg;
        phase_next = phase_reg;
        ptr_next   = ptr_reg;
        fill_next  = fill_reg;
        boot_next  = boot_reg;
        done_next  = 1'b0;
        pos_next   = pos_reg;
        value_next = value_reg;
        rd_ok_next = rd_ok_reg;
        opa        = base_reg;
        opb        = SW'(col_reg);
        lim        = SW'(CELLS);
        we         = 1'b0;
        waddr      = ptr_reg[AW-1:0];
        wdata      = fill_reg;
        re         = 1'b0;
        raddr      = idx_ext[AW-1:0];
        wrap       = (col_reg >= CW'(COLUMNS));
        row_after  = row_reg + RW'(wrap);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // unit gives the linear cursor cell
                state_next = S_FIN;
                unique case (act_reg)
                    ACT_PUT:
                    begin
                        state_next = S_WRAP;
                        if (byte_reg == CH_BS)
                        begin
                            if (col_reg != '0)
                            begin
                                col_next   = col_reg - CW'(1);
                                phase_next = (phase_reg == '0) ? PW'(TAB_STOP - 1)
                                                               : phase_reg - PW'(1);
                            end
                        end
                        else if (byte_reg == CH_TAB)
                        begin
                            col_next   = col_reg + (CW'(TAB_STOP) - CW'(phase_reg));
                            phase_next = '0;
                        end
                        else if (byte_reg == CH_CR)
                        begin
                            col_next   = '0;
                            phase_next = '0;
                        end
                        else if (byte_reg == CH_LF)
                        begin
                            col_next   = '0;
                            phase_next = '0;
                            row_next   = row_reg + RW'(1);
                            base_next  = base_reg + SW'(COLUMNS);
                        end
                        else if (byte_reg >= CH_SPACE && byte_reg <= CH_LAST)
                        begin
                            we         = 1'b1;
                            waddr      = sum[AW-1:0];
                            wdata      = {attr_reg, byte_reg};
                            col_next   = col_reg + CW'(1);
                            phase_next = (phase_reg == PW'(TAB_STOP - 1)) ? '0
                                                                          : phase_reg + PW'(1);
                        end
                    end
                    ACT_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        base_next  = '0;
                        phase_next = '0;
                        ptr_next   = '0;
                        fill_next  = CLEAR_CELL;
                        state_next = S_FILL;
                    end
                    ACT_READ:
                    begin
                        rd_ok_next = (idx_ext < SW'(CELLS));
                        re         = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_WRAP:
            begin
                // wrap at end of row, scroll past the last row
                state_next = S_FIN;
                if (wrap)
                begin
                    col_next   = '0;
                    phase_next = '0;
                end
                if (row_after == RW'(ROWS))
                begin
                    row_next   = RW'(ROWS - 1);
                    base_next  = SW'((ROWS - 1) * COLUMNS);
                    ptr_next   = '0;
                    fill_next  = {attr_reg, CH_SPACE};
                    state_next = S_SCR_RD;
                end
                else if (wrap)
                begin
                    row_next  = row_after;
                    base_next = base_reg + SW'(COLUMNS);
                end
            end

            S_SCR_RD:
            begin
                // fetch the cell one row below
                opa        = ptr_reg;
                opb        = SW'(COLUMNS);
                re         = 1'b1;
                raddr      = sum[AW-1:0];
                state_next = S_SCR_WR;
            end

            S_SCR_WR:
            begin
                // move it up and step the pointer
                opa      = ptr_reg;
                opb      = SW'(1);
                lim      = SW'(CELLS - COLUMNS);
                we       = 1'b1;
                wdata    = rdata;
                ptr_next = sum;
                state_next = below ? S_SCR_RD : S_FILL;
            end

            S_FILL:
            begin
                // one cell per cycle up to the end of the store
                opa      = ptr_reg;
                opb      = SW'(1);
                lim      = SW'(CELLS);
                we       = 1'b1;
                ptr_next = sum;
                if (!below)
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_FIN;
                end
            end

            S_FIN:
            begin
                // unit gives the final cursor position
                done_next  = 1'b1;
                pos_next   = sum[POS_W-1:0];
                value_next = (act_reg == ACT_READ && rd_ok_reg) ? rdata : '0;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            col_reg   <= '0;
            row_reg   <= '0;
            base_reg  <= '0;
            phase_reg <= '0;
            ptr_reg   <= '0;
            fill_reg  <= CLEAR_CELL;
            boot_reg  <= 1'b1;
            done_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
            attr_reg  <= ATTR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
            phase_reg <= phase_next;
            ptr_reg   <= ptr_next;
            fill_reg  <= fill_next;
            boot_reg  <= boot_next;
            done_reg  <= done_next;
            rd_ok_reg <= rd_ok_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        value_reg <= value_next;
        if (accept)
        begin
            act_reg  <= action;
            byte_reg <= char_byte;
            idx_reg  <= cell_index;
        end
    end

    // checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (row_reg < RW'(ROWS) && col_reg < CW'(COLUMNS)))
        else $error("cursor outside screen while idle");

    a_base_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (base_reg == SW'(row_reg) * SW'(COLUMNS)))
        else $error("row base out of step with cursor row");

    a_phase_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (CW'(phase_reg) == col_reg % CW'(TAB_STOP)))
        else $error("tab phase out of step with cursor column");

endmodule

`default_nettype wire

// ===== sim/tb_text_console_cursor_engine_top.sv =====
// self-checking testbench for text_console_cursor_engine_top
// drives put, clear, read and spare actions with random gaps and checks each strobed
// result against a typed value or an in-bench console model; depends on tcce_pkg and the design files
`default_nettype none

module tb_text_console_cursor_engine_top;
    import tcce_pkg::*;

    localparam int COLUMNS  = COLUMNS_DEF;
    localparam int ROWS     = ROWS_DEF;
    localparam int TAB_STOP = TAB_STOP_DEF;
    localparam int CELLS    = ROWS * COLUMNS;

    // action code the block leaves unused
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int GAP_MAX         = 17;
    localparam int unsigned CYCLE_LIMIT = 32_000_000;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] val;
    } readout_t;

    typedef struct packed {
        logic [1:0]         act;
        logic [7:0]         ch;
        logic [INDEX_W-1:0] idx;
        logic               typed;
        logic [POS_W-1:0]   pos;
        logic [CELL_W-1:0]  val;
    } opening_row_t;

    localparam int OPENING_N = 24;

    // opening rows: typed results where they follow directly from reset state
    opening_row_t opening_rows [OPENING_N] = '{
        '{ACT_READ,  8'h00,    11'd0,    1'b1, 11'd0,  16'h0020},
        '{ACT_READ,  8'h00,    11'd1999, 1'b1, 11'd0,  16'h0020},
        '{ACT_READ,  8'h00,    11'd2047, 1'b1, 11'd0,  16'h0000},
        '{ACT_SPARE, 8'hFF,    11'h7FF,  1'b1, 11'd0,  16'h0000},
        '{ACT_PUT,   CH_BS,    11'd0,    1'b1, 11'd0,  16'h0000},
        '{ACT_PUT,   CH_SPACE, 11'd0,    1'b1, 11'd1,  16'h0000},
        '{ACT_PUT,   CH_LAST,  11'd0,    1'b1, 11'd2,  16'h0000},
        '{ACT_PUT,   8'h1F,    11'd0,    1'b1, 11'd2,  16'h0000},
        '{ACT_PUT,   8'h80,    11'd0,    1'b1, 11'd2,  16'h0000},
        '{ACT_PUT,   8'hFF,    11'h7FF,  1'b1, 11'd2,  16'h0000},
        '{ACT_PUT,   8'h00,    11'd0,    1'b1, 11'd2,  16'h0000},
        '{ACT_PUT,   CH_TAB,   11'd0,    1'b1, 11'd4,  16'h0000},
        '{ACT_PUT,   CH_TAB,   11'd0,    1'b1, 11'd8,  16'h0000},
        '{ACT_PUT,   CH_BS,    11'd0,    1'b1, 11'd7,  16'h0000},
        '{ACT_READ,  8'h00,    11'd0,    1'b1, 11'd7,  16'h0F20},
        '{ACT_READ,  8'h00,    11'd1,    1'b1, 11'd7,  16'h0F7F},
        '{ACT_PUT,   CH_CR,    11'd0,    1'b1, 11'd0,  16'h0000},
        '{ACT_PUT,   CH_LF,    11'd0,    1'b1, 11'd80, 16'h0000},
        '{ACT_PUT,   8'h41,    11'd0,    1'b0, 11'd0,  16'h0000},
        '{ACT_READ,  8'h00,    11'd80,   1'b0, 11'd0,  16'h0000},
        '{ACT_PUT,   8'h7E,    11'd0,    1'b0, 11'd0,  16'h0000},
        '{ACT_CLEAR, 8'h00,    11'd0,    1'b1, 11'd0,  16'h0000},
        '{ACT_READ,  8'h00,    11'd80,   1'b1, 11'd0,  16'h0020},
        '{ACT_READ,  8'h00,    11'd1998, 1'b0, 11'd0,  16'h0000}
    };

    // per-phase mix: line feed and clear weights in percent, attribute (-1 random)
    int lf_weight    [PHASES] = '{4, 2, 25, 0, 6, 12, 3};
    int clear_weight [PHASES] = '{3, 2, 0, 0, 2, 1, 4};
    int attr_plan    [PHASES] = '{0, 255, -1, 15, -1, 255, -1};

    // block ports
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    logic [1:0]           action     = ACT_PUT;
    logic [7:0]           char_byte  = 8'h00;
    logic [INDEX_W-1:0]   cell_index = '0;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [7:0]           cfg_data   = 8'h00;
    logic                 done;
    logic [POS_W-1:0]     cursor_position;
    logic [CELL_W-1:0]    cell_value;

    // console copy kept by the bench
    logic [CELL_W-1:0] screen_copy [CELLS];
    int                cur_col;
    int                cur_row;
    logic [7:0]        attr_now;

    readout_t    readouts_due [$];
    readout_t    head;
    int          errors_seen     = 0;
    int          items_sent      = 0;
    int          results_checked = 0;
    int          scrolls_modeled = 0;
    int          clears_modeled  = 0;
    int          attrs_written   = 0;
    int          burst_left      = 0;
    int unsigned cycle_count     = 0;

    text_console_cursor_engine_top #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .char_byte       (char_byte),
        .cell_index      (cell_index),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .done            (done),
        .cursor_position (cursor_position),
        .cell_value      (cell_value)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_text_console_cursor_engine_top: errors");
            $finish;
        end
    end

    // advance the console copy by one item and return its readout
    function readout_t console_step(input logic [1:0] act, input logic [7:0] ch,
                                    input logic [INDEX_W-1:0] idx);
        readout_t r;
        int k;
        r.val = '0;
        if (act == ACT_PUT)
        begin
            if (ch == CH_BS)
            begin
                if (cur_col > 0)
                    cur_col = cur_col - 1;
            end
            else if (ch == CH_TAB)
                cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
            else if (ch == CH_CR)
                cur_col = 0;
            else if (ch == CH_LF)
            begin
                cur_row = cur_row + 1;
                cur_col = 0;
            end
            else if (ch >= CH_SPACE && ch <= CH_LAST)
            begin
                screen_copy[cur_row * COLUMNS + cur_col] = {attr_now, ch};
                cur_col = cur_col + 1;
            end
            // wrap at end of row
            if (cur_col >= COLUMNS)
            begin
                cur_row = cur_row + 1;
                cur_col = 0;
            end
            // scroll up one row past the bottom
            if (cur_row >= ROWS)
            begin
                for (k = 0; k < (ROWS - 1) * COLUMNS; k++)
                    screen_copy[k] = screen_copy[k + COLUMNS];
                for (k = 0; k < COLUMNS; k++)
                    screen_copy[(ROWS - 1) * COLUMNS + k] = {attr_now, CH_SPACE};
                cur_row = ROWS - 1;
                scrolls_modeled++;
            end
        end
        else if (act == ACT_CLEAR)
        begin
            for (k = 0; k < CELLS; k++)
                screen_copy[k] = CLEAR_CELL;
            cur_col = 0;
            cur_row = 0;
            clears_modeled++;
        end
        else if (act == ACT_READ)
        begin
            if (idx < CELLS)
                r.val = screen_copy[idx];
        end
        r.pos = POS_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    // present one item after a random gap and record its readout once taken
    task automatic drive_item(input logic [1:0] act, input logic [7:0] ch,
                              input logic [INDEX_W-1:0] idx, input logic typed,
                              input readout_t typed_val);
        int gap;
        readout_t want;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, GAP_MAX);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(8, 30);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        char_byte  <= ch;
        cell_index <= idx;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        want = console_step(act, ch, idx);
        if (typed)
            want = typed_val;
        readouts_due.push_back(want);
        items_sent++;
    endtask

    // stop issuing and wait for every pending readout
    task automatic wait_idle();
        start <= 1'b0;
        while (readouts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the attribute register through its own channel
    task automatic set_attribute(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        attr_now = value;
        attrs_written++;
    endtask

    // result checker: the receiver takes every strobe
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (readouts_due.size() == 0)
            begin
                $error("result with nothing pending: cursor_position %0d cell_value %h",
                       cursor_position, cell_value);
                errors_seen++;
            end
            else
            begin
                head = readouts_due.pop_front();
                results_checked++;
                if (cursor_position !== head.pos)
                begin
                    $error("cursor_position: expected %0d, got %0d", head.pos,
                           cursor_position);
                    errors_seen++;
                end
                if (cell_value !== head.val)
                begin
                    $error("cell_value: expected %h, got %h", head.val, cell_value);
                    errors_seen++;
                end
            end
        end
    end

    initial
    begin
        int                 ph;
        int                 n;
        int                 r;
        int                 q;
        int                 av;
        logic [1:0]         act;
        logic [7:0]         ch;
        logic [INDEX_W-1:0] idx;
        readout_t           typed_val;

        for (n = 0; n < CELLS; n++)
            screen_copy[n] = CLEAR_CELL;
        cur_col  = 0;
        cur_row  = 0;
        attr_now = ATTR_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening
        for (n = 0; n < OPENING_N; n++)
        begin
            typed_val.pos = opening_rows[n].pos;
            typed_val.val = opening_rows[n].val;
            drive_item(opening_rows[n].act, opening_rows[n].ch, opening_rows[n].idx,
                       opening_rows[n].typed, typed_val);
        end

        // random phases, each under its own attribute
        typed_val = '0;
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            av = (attr_plan[ph] < 0) ? $urandom_range(0, 255) : attr_plan[ph];
            set_attribute(8'(av));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                ch  = 8'($urandom_range(0, 255));
                idx = INDEX_W'($urandom_range(0, 2047));
                r   = $urandom_range(0, 99);
                if (r < clear_weight[ph])
                    act = ACT_CLEAR;
                else if (r < clear_weight[ph] + 2)
                    act = ACT_SPARE;
                else if (r < clear_weight[ph] + 22)
                begin
                    act = ACT_READ;
                    if ($urandom_range(0, 6) == 0)
                        idx = INDEX_W'($urandom_range(CELLS, 2047));
                    else
                        idx = INDEX_W'($urandom_range(0, CELLS - 1));
                end
                else
                begin
                    act = ACT_PUT;
                    q   = $urandom_range(0, 99);
                    if (q < lf_weight[ph])
                        ch = CH_LF;
                    else if (q < lf_weight[ph] + 6)
                        ch = CH_TAB;
                    else if (q < lf_weight[ph] + 11)
                        ch = CH_BS;
                    else if (q < lf_weight[ph] + 15)
                        ch = CH_CR;
                    else if (q < lf_weight[ph] + 75)
                        ch = 8'($urandom_range(CH_SPACE, CH_LAST));
                end
                drive_item(act, ch, idx, 1'b0, typed_val);
            end
        end

        // drain and report
        wait_idle();
        repeat (10) @(posedge clk);
        $display("%0d items driven, %0d results checked, %0d attribute writes",
                 items_sent, results_checked, attrs_written);
        $display("console model saw %0d clears and %0d scrolls", clears_modeled,
                 scrolls_modeled);
        if (errors_seen == 0)
            $display("tb_text_console_cursor_engine_top: clean");
        else
            $display("tb_text_console_cursor_engine_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
